[rtl/rgb2ryb_pkg.sv]
package rgb2ryb_pkg;

  // pixel channel and result widths
  localparam int IN_W   = 8;
  localparam int OUT_W  = 13;
  localparam int NUM_CH = 3;

  // result channel order
  localparam int CH_RED    = 0;
  localparam int CH_YELLOW = 1;
  localparam int CH_BLUE   = 2;

  // full scale of one input channel, and the blend denominator 255^3
  localparam int CH_MAX     = 255;
  localparam int DENOM      = CH_MAX * CH_MAX * CH_MAX;
  localparam int HALF_DENOM = (DENOM - 1) / 2;

  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  // decimal thousandths to fixed point, rounded to nearest
  function automatic longint milli_q(input int k, input int frac);
    return ((longint'(k) << frac) + 64'sd500) / 64'sd1000;
  endfunction

endpackage

[rtl/rgb_to_ryb_trilinear_convert.sv]
// rgb to ryb conversion by trilinear blend of an eight-corner color table
// the result strobe follows a taken request down the stage valid bits, stage 1 through stage 9
// throughput: one pixel per clock, busy never asserts, results cannot be held off
// reset: synchronous active-low rst_n clears the stage valid bits only,
// so no strobe follows reset until a new request is taken
module rgb_to_ryb_trilinear_convert #(
  parameter int FRAC_BITS = 12
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [rgb2ryb_pkg::IN_W-1:0]   in_red,
  input  logic [rgb2ryb_pkg::IN_W-1:0]   in_green,
  input  logic [rgb2ryb_pkg::IN_W-1:0]   in_blue,
  output logic                           out_valid,
  output logic [rgb2ryb_pkg::OUT_W-1:0]  out_ryb_red,
  output logic [rgb2ryb_pkg::OUT_W-1:0]  out_ryb_yellow,
  output logic [rgb2ryb_pkg::OUT_W-1:0]  out_ryb_blue
);

  import rgb2ryb_pkg::*;

  // stage widths: every blend step along one axis adds 8 bits
  localparam int C_W   = FRAC_BITS + 8;    // after the blue axis
  localparam int D_W   = FRAC_BITS + 16;   // after the yellow axis
  localparam int ACC_W = FRAC_BITS + 24;   // after the red axis, plus half denominator
  // each divide by 255 drops 7 bits of range
  localparam int Q1_W  = ACC_W - 7;
  localparam int Q2_W  = ACC_W - 14;
  localparam int Q3_W  = ACC_W - 21;
  localparam int SAT_W = (Q3_W > OUT_W) ? Q3_W : OUT_W;
  // base-256 terms of the 1/255 series
  localparam int NT    = (ACC_W + 7) / 8;
  localparam int NSTG  = 9;

  // corner colors in fixed point
  localparam logic [FRAC_BITS:0] ONE_Q  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [FRAC_BITS:0] ZERO_Q = '0;
  localparam logic [FRAC_BITS:0] K483   = (FRAC_BITS+1)'(milli_q(483, FRAC_BITS));
  localparam logic [FRAC_BITS:0] K309   = (FRAC_BITS+1)'(milli_q(309, FRAC_BITS));
  localparam logic [FRAC_BITS:0] K469   = (FRAC_BITS+1)'(milli_q(469, FRAC_BITS));
  localparam logic [FRAC_BITS:0] K053   = (FRAC_BITS+1)'(milli_q(53, FRAC_BITS));
  localparam logic [FRAC_BITS:0] K210   = (FRAC_BITS+1)'(milli_q(210, FRAC_BITS));

  // table indexed by the corner bits {r, y, b}, a set bit meaning the channel itself
  // and a clear bit its complement; columns are red, yellow, blue
  localparam logic [FRAC_BITS:0] CORNER [8][NUM_CH] = '{
    '{ONE_Q,  ONE_Q,  ONE_Q },   // white
    '{ONE_Q,  ZERO_Q, ZERO_Q},   // blue corner
    '{ZERO_Q, ONE_Q,  K483  },   // yellow corner
    '{ZERO_Q, ZERO_Q, ONE_Q },   // yellow and blue
    '{ZERO_Q, ONE_Q,  ZERO_Q},   // red corner
    '{K309,   ZERO_Q, K469  },   // red and blue
    '{ZERO_Q, K053,   K210  },   // red and yellow
    '{ZERO_Q, ZERO_Q, ZERO_Q}    // black
  };

  // estimate of floor(x / 255) from the series 1/255 = sum of 256^-k,
  // low by at most one
  function automatic logic [ACC_W-1:0] div_est(input logic [ACC_W-1:0] x);
    logic [ACC_W:0] sum;
    sum = (ACC_W+1)'(x);
    for (int k = 1; k <= NT; k++) begin
      sum = sum + (ACC_W+1)'(x >> (8 * k));
    end
    return ACC_W'(sum >> 8);
  endfunction

  // remainder x - 255 q stays below 510, so ten low bits settle the last step
  function automatic logic [ACC_W-1:0] div_fix(input logic [ACC_W-1:0] q,
                                               input logic [9:0] x_lo);
    logic [9:0] rem;
    rem = x_lo - ((q[9:0] << 8) - q[9:0]);
    if (rem >= 10'(CH_MAX)) begin
      return q + ACC_W'(1);
    end
    return q;
  endfunction

  // stage valid bits, one per pipeline register stage
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;

  // complements 255 - v
  logic [IN_W-1:0] nb;
  logic [IN_W-1:0] ny1;
  logic [IN_W-1:0] nr2;

  // stage 1: blue axis blended, four (r, y) corners per channel
  logic [C_W-1:0]  c_r   [4][NUM_CH];
  logic [C_W-1:0]  c_nxt [4][NUM_CH];
  logic [IN_W-1:0] red1_r, green1_r;
  // stage 2: yellow axis blended
  logic [D_W-1:0]  d_r   [2][NUM_CH];
  logic [D_W-1:0]  d_nxt [2][NUM_CH];
  logic [IN_W-1:0] red2_r;
  // stage 3: red axis blended, rounding offset added
  logic [ACC_W-1:0] acc_r   [NUM_CH];
  logic [ACC_W-1:0] acc_nxt [NUM_CH];
  // stages 4 to 9: three divides by 255, estimate then fix
  logic [Q1_W-1:0] e1_r [NUM_CH];
  logic [Q1_W-1:0] e1_nxt [NUM_CH];
  logic [Q1_W-1:0] q1_r [NUM_CH];
  logic [Q1_W-1:0] q1_nxt [NUM_CH];
  logic [Q2_W-1:0] e2_r [NUM_CH];
  logic [Q2_W-1:0] e2_nxt [NUM_CH];
  logic [Q2_W-1:0] q2_r [NUM_CH];
  logic [Q2_W-1:0] q2_nxt [NUM_CH];
  logic [Q3_W-1:0] e3_r [NUM_CH];
  logic [Q3_W-1:0] e3_nxt [NUM_CH];
  logic [9:0]      lo1_r [NUM_CH];
  logic [9:0]      lo2_r [NUM_CH];
  logic [9:0]      lo3_r [NUM_CH];
  logic [9:0]      lo1_nxt [NUM_CH];
  logic [9:0]      lo2_nxt [NUM_CH];
  logic [9:0]      lo3_nxt [NUM_CH];
  logic [SAT_W-1:0] q3 [NUM_CH];
  // stage 9: saturated results
  logic [OUT_W-1:0] res_r   [NUM_CH];
  logic [OUT_W-1:0] res_nxt [NUM_CH];

  // the pipeline never stalls, so a request is taken whenever start is high
  assign busy    = 1'b0;
  assign vld_nxt = {vld_r[NSTG-2:0], start & ~busy};

  assign nb  = ~in_blue;
  assign ny1 = ~green1_r;
  assign nr2 = ~red2_r;

  always_comb begin
    for (int ry = 0; ry < 4; ry++) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        c_nxt[ry][ch] = C_W'(CORNER[2*ry][ch]) * C_W'(nb)
                      + C_W'(CORNER[2*ry+1][ch]) * C_W'(in_blue);
      end
    end
    for (int rr = 0; rr < 2; rr++) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        d_nxt[rr][ch] = D_W'(ny1) * D_W'(c_r[2*rr][ch])
                      + D_W'(green1_r) * D_W'(c_r[2*rr+1][ch]);
      end
    end
    for (int ch = 0; ch < NUM_CH; ch++) begin
      // rounding to nearest: add half of the odd denominator before flooring
      acc_nxt[ch] = ACC_W'(nr2) * ACC_W'(d_r[0][ch])
                  + ACC_W'(red2_r) * ACC_W'(d_r[1][ch])
                  + ACC_W'(HALF_DENOM);
      // floor(x / 255^3) taken as three nested floors of x / 255
      e1_nxt[ch]  = Q1_W'(div_est(acc_r[ch]));
      lo1_nxt[ch] = acc_r[ch][9:0];
      q1_nxt[ch]  = Q1_W'(div_fix(ACC_W'(e1_r[ch]), lo1_r[ch]));
      e2_nxt[ch]  = Q2_W'(div_est(ACC_W'(q1_r[ch])));
      lo2_nxt[ch] = q1_r[ch][9:0];
      q2_nxt[ch]  = Q2_W'(div_fix(ACC_W'(e2_r[ch]), lo2_r[ch]));
      e3_nxt[ch]  = Q3_W'(div_est(ACC_W'(q2_r[ch])));
      lo3_nxt[ch] = q2_r[ch][9:0];
      q3[ch]      = SAT_W'(div_fix(ACC_W'(e3_r[ch]), lo3_r[ch]));
      // only wide fraction settings can exceed the result range
      if (q3[ch] > SAT_W'(OUT_MAX)) begin
        res_nxt[ch] = OUT_MAX;
      end else begin
        res_nxt[ch] = q3[ch][OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // data registers load every cycle, the valid bits mark what they hold
  always_ff @(posedge clk) begin
    red1_r   <= in_red;
    green1_r <= in_green;
    red2_r   <= red1_r;
    c_r      <= c_nxt;
    d_r      <= d_nxt;
    acc_r    <= acc_nxt;
    e1_r     <= e1_nxt;
    lo1_r    <= lo1_nxt;
    q1_r     <= q1_nxt;
    e2_r     <= e2_nxt;
    lo2_r    <= lo2_nxt;
    q2_r     <= q2_nxt;
    e3_r     <= e3_nxt;
    lo3_r    <= lo3_nxt;
    res_r    <= res_nxt;
  end

  assign out_valid      = vld_r[NSTG-1];
  assign out_ryb_red    = res_r[CH_RED];
  assign out_ryb_yellow = res_r[CH_YELLOW];
  assign out_ryb_blue   = res_r[CH_BLUE];

endmodule
